[sv/dfasm_pkg.sv]
// ----------------------------------------------------------------------------
// dfasm_pkg
// Shared widths, codes and helpers for the decimal fixed-point add/sub/mul unit.
// ----------------------------------------------------------------------------
package dfasm_pkg;

    // Width of one decimal part held as a binary integer
    localparam int DW = 60;
    // Half width, the operand split used by the partial products
    localparam int HW = DW / 2;
    // Stages of the reciprocal divide by 10^DIGITS
    localparam int DSTG = 5;

    // Operation codes; bit 1 of kind selects multiply
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    // Unused code, decodes as multiply
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int KIND_MUL_BIT = 1;

    // Product lanes: fraction and whole parts crossed
    localparam int LN_FF = 0;
    localparam int LN_WF = 1;
    localparam int LN_FW = 2;
    localparam int LN_WW = 3;
    localparam int NLANE = 4;

    // Partial products of one 60 x 60 lane
    localparam int PP_LL = 0;
    localparam int PP_LH = 1;
    localparam int PP_HL = 2;
    localparam int PP_HH = 3;
    localparam int NPP = 4;

    // Result carried alongside the multiply datapath
    typedef struct packed {
        logic          is_mul;
        logic          neg;
        logic [DW-1:0] whole;
        logic [DW-1:0] frac;
        logic          ovf;
    } res_t;

    // 10^n, evaluated at elaboration
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] s;
        s = 64'd1;
        for (int i = 0; i < n && i < 18; i++)
        begin
            s = s * 64'd10;
        end
        return s;
    endfunction

endpackage

[sv/decimal_fixed_add_sub_mul.sv]
// ----------------------------------------------------------------------------
// decimal_fixed_add_sub_mul
// Sign-magnitude decimal fixed-point add, subtract and multiply, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: 2 operand stages, product sum, 5 reciprocal divider stages,
//   2 fraction stages, output; the constant-divide pipeline sets the depth.
// Throughput: one beat per cycle while out_ready is high.
// Reset: rst_n clears all stage valid bits; payload registers are not reset.
module decimal_fixed_add_sub_mul #(
    parameter int DIGITS = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic                      a_negative,
    input  logic [dfasm_pkg::DW-1:0]  a_whole,
    input  logic [dfasm_pkg::DW-1:0]  a_fraction,
    input  logic                      b_negative,
    input  logic [dfasm_pkg::DW-1:0]  b_whole,
    input  logic [dfasm_pkg::DW-1:0]  b_fraction,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      res_negative,
    output logic [dfasm_pkg::DW-1:0]  res_whole,
    output logic [dfasm_pkg::DW-1:0]  res_fraction,
    output logic                      out_of_range
);
    import dfasm_pkg::*;

    // One unit of the whole part, in fraction units
    localparam logic [DW-1:0] SCALE = DW'(pow10(DIGITS));
    localparam logic [DW-1:0] HALF  = SCALE >> 1;

    // Stage map
    localparam int ST_IN   = 0;              // saturated operands
    localparam int ST_PP   = 1;              // 30x30 partial products, add/sub sums
    localparam int ST_SUM  = 2;              // 120-bit products, add/sub result
    localparam int ST_DIV0 = 3;              // first divider stage
    localparam int ST_FR1  = ST_DIV0 + DSTG; // round and first fraction carry
    localparam int ST_FR2  = ST_FR1 + 1;     // second fraction carry, integer sum
    localparam int ST_OUT  = ST_FR2 + 1;     // overflow check, output register
    localparam int NSTG    = ST_OUT + 1;
    localparam int NRES    = ST_FR2 - ST_DIV0 + 1;

    // ------------------------------------------------------------------------
    // Flow control: each stage loads when it is empty or its successor loads,
    // so bubbles collapse and an input beat is taken while the output waits.
    // ------------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    assign en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
    for (genvar i = 0; i < NSTG - 1; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    assign in_ready  = en[ST_IN];
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: clamp each part to 10^DIGITS - 1 and capture the operands.
    // ------------------------------------------------------------------------
    logic          mul0_reg, sub0_reg, an0_reg, bn0_reg;
    logic [DW-1:0] aw0_reg, af0_reg, bw0_reg, bf0_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            mul0_reg <= kind[KIND_MUL_BIT];
            sub0_reg <= (kind == KIND_SUB);
            an0_reg  <= a_negative;
            bn0_reg  <= b_negative;
            aw0_reg  <= (a_whole    >= SCALE) ? SCALE - DW'(1) : a_whole;
            af0_reg  <= (a_fraction >= SCALE) ? SCALE - DW'(1) : a_fraction;
            bw0_reg  <= (b_whole    >= SCALE) ? SCALE - DW'(1) : b_whole;
            bf0_reg  <= (b_fraction >= SCALE) ? SCALE - DW'(1) : b_fraction;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: four product lanes split into 30x30 partial products; the
    // add/sub path forms both sums and the magnitude compare.
    // ------------------------------------------------------------------------
    logic [DW-1:0] lx [NLANE];
    logic [DW-1:0] ly [NLANE];

    always_comb
    begin
        lx[LN_FF] = af0_reg;  ly[LN_FF] = bf0_reg;
        lx[LN_WF] = aw0_reg;  ly[LN_WF] = bf0_reg;
        lx[LN_FW] = af0_reg;  ly[LN_FW] = bw0_reg;
        lx[LN_WW] = aw0_reg;  ly[LN_WW] = bw0_reg;
    end

    logic [DW-1:0] pp1_reg [NLANE][NPP];
    logic          mul1_reg, sub1_reg, an1_reg, bn1_reg;
    logic [DW-1:0] aw1_reg, af1_reg, bw1_reg, bf1_reg;
    logic [DW:0]   fsum1_reg, wsum1_reg;
    logic          aless1_reg, equal1_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PP])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                pp1_reg[l][PP_LL] <= {{HW{1'b0}}, lx[l][HW-1:0]}
                                   * {{HW{1'b0}}, ly[l][HW-1:0]};
                pp1_reg[l][PP_LH] <= {{HW{1'b0}}, lx[l][HW-1:0]}
                                   * {{HW{1'b0}}, ly[l][DW-1:HW]};
                pp1_reg[l][PP_HL] <= {{HW{1'b0}}, lx[l][DW-1:HW]}
                                   * {{HW{1'b0}}, ly[l][HW-1:0]};
                pp1_reg[l][PP_HH] <= {{HW{1'b0}}, lx[l][DW-1:HW]}
                                   * {{HW{1'b0}}, ly[l][DW-1:HW]};
            end
            mul1_reg   <= mul0_reg;
            sub1_reg   <= sub0_reg;
            an1_reg    <= an0_reg;
            bn1_reg    <= bn0_reg;
            aw1_reg    <= aw0_reg;
            af1_reg    <= af0_reg;
            bw1_reg    <= bw0_reg;
            bf1_reg    <= bf0_reg;
            fsum1_reg  <= {1'b0, af0_reg} + {1'b0, bf0_reg};
            wsum1_reg  <= {1'b0, aw0_reg} + {1'b0, bw0_reg};
            aless1_reg <= (aw0_reg < bw0_reg) || (aw0_reg == bw0_reg && af0_reg < bf0_reg);
            equal1_reg <= (aw0_reg == bw0_reg) && (af0_reg == bf0_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: sum partial products into full 120-bit products; finish the
    // magnitude add or subtract.
    // ------------------------------------------------------------------------
    logic          ebn1, same1, add_carry, borrow;
    logic [DW-1:0] add_f, sub_f, sub_w, gw, gf, lw, lf;
    logic [DW:0]   add_w;
    logic          as_neg_next;

    always_comb
    begin
        ebn1      = bn1_reg ^ sub1_reg;
        same1     = (an1_reg == ebn1);
        add_carry = (fsum1_reg >= {1'b0, SCALE});
        add_f     = add_carry ? DW'(fsum1_reg - {1'b0, SCALE}) : fsum1_reg[DW-1:0];
        add_w     = wsum1_reg + {{DW{1'b0}}, add_carry};
        gw        = aless1_reg ? bw1_reg : aw1_reg;
        gf        = aless1_reg ? bf1_reg : af1_reg;
        lw        = aless1_reg ? aw1_reg : bw1_reg;
        lf        = aless1_reg ? af1_reg : bf1_reg;
        borrow    = (gf < lf);
        sub_f     = DW'({1'b0, gf} + (borrow ? {1'b0, SCALE} : {(DW+1){1'b0}}) - {1'b0, lf});
        sub_w     = gw - lw - {{(DW-1){1'b0}}, borrow};
        if (same1)
        begin
            as_neg_next = an1_reg;
        end
        else if (equal1_reg)
        begin
            // exact-zero difference: subtract keeps a's sign, add gives plus
            as_neg_next = sub1_reg ? an1_reg : 1'b0;
        end
        else
        begin
            as_neg_next = aless1_reg ? ebn1 : an1_reg;
        end
    end

    logic [2*DW-1:0] prod2_reg [NLANE];
    logic            mul2_reg, mneg2_reg, add2_reg, asneg2_reg;
    logic [DW:0]     asw2_reg;
    logic [DW-1:0]   asf2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                prod2_reg[l] <= {pp1_reg[l][PP_HH], {DW{1'b0}}}
                              + {{HW{1'b0}}, pp1_reg[l][PP_LH], {HW{1'b0}}}
                              + {{HW{1'b0}}, pp1_reg[l][PP_HL], {HW{1'b0}}}
                              + {{DW{1'b0}}, pp1_reg[l][PP_LL]};
            end
            mul2_reg   <= mul1_reg;
            mneg2_reg  <= an1_reg ^ bn1_reg;
            add2_reg   <= same1;
            asneg2_reg <= as_neg_next;
            asw2_reg   <= same1 ? add_w : {1'b0, sub_w};
            asf2_reg   <= same1 ? add_f : sub_f;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 3..7: divide each product by 10^DIGITS with a reciprocal. The
    // top product bits times the reciprocal give an estimate at most two
    // below the quotient; the remainder then settles it with two compares.
    // ------------------------------------------------------------------------
    // TS is floor(log2 of the scale), RECIP = floor(2^(TS+64) / scale)
    localparam int           TS      = $clog2({4'd0, SCALE} + 64'd1) - 1;
    localparam logic [127:0] RECIP_W = (128'd1 << (TS + 64)) / {68'd0, SCALE};
    localparam logic [31:0]  RC_LO   = RECIP_W[31:0];
    localparam logic [31:0]  RC_HI   = RECIP_W[63:32];
    localparam logic [31:0]  SC_LO   = SCALE[31:0];
    localparam logic [31:0]  SC_HI   = {4'd0, SCALE[DW-1:32]};
    localparam logic [63:0]  SCALE_W = {4'd0, SCALE};
    localparam logic [63:0]  SCALE2  = {3'd0, SCALE, 1'b0};

    logic [63:0] mq1_reg  [NLANE][NPP];
    logic [63:0] plo1_reg [NLANE];
    res_t        res_reg  [NRES];
    res_t        res_first;

    always_comb
    begin
        res_first        = '0;
        res_first.is_mul = mul2_reg;
        if (mul2_reg)
        begin
            res_first.neg = mneg2_reg;
        end
        else if (add2_reg && asw2_reg >= {1'b0, SCALE})
        begin
            // integer part reached 10^DIGITS: flag and zero the value
            res_first.ovf = 1'b1;
        end
        else
        begin
            res_first.neg   = asneg2_reg;
            res_first.whole = asw2_reg[DW-1:0];
            res_first.frac  = asf2_reg;
        end
    end

    // Stage 3: top 61 product bits times the reciprocal, as 32x32 pieces
    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                mq1_reg[l][PP_LL] <= {32'd0, prod2_reg[l][TS +: 32]} * {32'd0, RC_LO};
                mq1_reg[l][PP_LH] <= {32'd0, prod2_reg[l][TS +: 32]} * {32'd0, RC_HI};
                mq1_reg[l][PP_HL] <= {35'd0, prod2_reg[l][TS+32 +: 29]} * {32'd0, RC_LO};
                mq1_reg[l][PP_HH] <= {35'd0, prod2_reg[l][TS+32 +: 29]} * {32'd0, RC_HI};
                plo1_reg[l]       <= prod2_reg[l][63:0];
            end
            res_reg[0] <= res_first;
        end
        // carry the add/sub result and multiply sign alongside
        for (int j = 1; j < NRES; j++)
        begin
            if (en[ST_DIV0+j])
            begin
                res_reg[j] <= res_reg[j-1];
            end
        end
    end

    // Stage 4: sum the pieces, keep bits 64 and up as the quotient estimate
    logic [127:0]  mqsum    [NLANE];
    logic [DW-1:0] qe2_reg  [NLANE];
    logic [63:0]   plo2_reg [NLANE];

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            mqsum[l] = {mq1_reg[l][PP_HH], 64'd0}
                     + {32'd0, mq1_reg[l][PP_LH], 32'd0}
                     + {32'd0, mq1_reg[l][PP_HL], 32'd0}
                     + {64'd0, mq1_reg[l][PP_LL]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0+1])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                qe2_reg[l]  <= mqsum[l][64 +: DW];
                plo2_reg[l] <= plo1_reg[l];
            end
        end
    end

    // Stage 5: low 64 bits of estimate times scale
    logic [63:0]   qs3_reg  [NLANE];
    logic [31:0]   qx3_reg  [NLANE];
    logic [DW-1:0] qe3_reg  [NLANE];
    logic [63:0]   plo3_reg [NLANE];

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0+2])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                qs3_reg[l]  <= {32'd0, qe2_reg[l][31:0]} * {32'd0, SC_LO};
                qx3_reg[l]  <= 32'({32'd0, qe2_reg[l][31:0]} * {32'd0, SC_HI})
                             + 32'({36'd0, qe2_reg[l][DW-1:32]} * {32'd0, SC_LO});
                qe3_reg[l]  <= qe2_reg[l];
                plo3_reg[l] <= plo2_reg[l];
            end
        end
    end

    // Stage 6: remainder of the estimate, below three units
    logic [63:0]   r4_reg  [NLANE];
    logic [DW-1:0] qe4_reg [NLANE];

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0+3])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                r4_reg[l]  <= plo3_reg[l] - qs3_reg[l] - {qx3_reg[l], 32'd0};
                qe4_reg[l] <= qe3_reg[l];
            end
        end
    end

    // Stage 7: advance the quotient by up to two and drop as many units
    logic [DW-1:0] quo5_reg [NLANE];
    logic [DW-1:0] rem5_reg [NLANE];

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0+4])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                if (r4_reg[l] >= SCALE2)
                begin
                    quo5_reg[l] <= qe4_reg[l] + DW'(2);
                    rem5_reg[l] <= DW'(r4_reg[l] - SCALE2);
                end
                else if (r4_reg[l] >= SCALE_W)
                begin
                    quo5_reg[l] <= qe4_reg[l] + DW'(1);
                    rem5_reg[l] <= DW'(r4_reg[l] - SCALE_W);
                end
                else
                begin
                    quo5_reg[l] <= qe4_reg[l];
                    rem5_reg[l] <= r4_reg[l][DW-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 8: round the fraction product and fold in the first cross term.
    // ------------------------------------------------------------------------
    logic [DW-1:0] q_ff, r_ff, q_wf, r_wf, q_fw, r_fw, q_ww, r_ww;
    logic [DW:0]   f1;
    logic          c1;

    always_comb
    begin
        q_ff = quo5_reg[LN_FF];  r_ff = rem5_reg[LN_FF];
        q_wf = quo5_reg[LN_WF];  r_wf = rem5_reg[LN_WF];
        q_fw = quo5_reg[LN_FW];  r_fw = rem5_reg[LN_FW];
        q_ww = quo5_reg[LN_WW];  r_ww = rem5_reg[LN_WW];
        // round up when the dropped digits exceed one half unit
        f1 = {1'b0, q_ff} + {1'b0, r_wf} + {{DW{1'b0}}, (r_ff > HALF)};
        c1 = (f1 >= {1'b0, SCALE});
    end

    logic [DW-1:0] frac3_reg, rfw3_reg, rww3_reg;
    logic [DW:0]   isum3_reg;
    logic          c13_reg, hinz3_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FR1])
        begin
            frac3_reg <= c1 ? DW'(f1 - {1'b0, SCALE}) : f1[DW-1:0];
            c13_reg   <= c1;
            isum3_reg <= {1'b0, q_wf} + {1'b0, q_fw};
            rfw3_reg  <= r_fw;
            rww3_reg  <= r_ww;
            hinz3_reg <= (q_ww != '0);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 9: second cross term into the fraction, integer part summed.
    // ------------------------------------------------------------------------
    logic [DW:0] f2;
    logic        c2;

    always_comb
    begin
        f2 = {1'b0, frac3_reg} + {1'b0, rfw3_reg};
        c2 = (f2 >= {1'b0, SCALE});
    end

    logic [DW-1:0] frac4_reg;
    logic [DW+1:0] integ4_reg;
    logic          hinz4_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FR2])
        begin
            frac4_reg  <= c2 ? DW'(f2 - {1'b0, SCALE}) : f2[DW-1:0];
            integ4_reg <= {1'b0, isum3_reg} + {2'b00, rww3_reg}
                        + {{(DW+1){1'b0}}, c13_reg} + {{(DW+1){1'b0}}, c2};
            hinz4_reg  <= hinz3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 10: overflow check for multiply and the output register.
    // ------------------------------------------------------------------------
    res_t res_last;
    res_t out_next;
    logic mul_ovf;

    always_comb
    begin
        res_last = res_reg[NRES-1];
        mul_ovf  = (integ4_reg >= {2'b00, SCALE}) || hinz4_reg;
        out_next = res_last;
        if (res_last.is_mul)
        begin
            if (mul_ovf)
            begin
                out_next.neg   = 1'b0;
                out_next.whole = '0;
                out_next.frac  = '0;
                out_next.ovf   = 1'b1;
            end
            else
            begin
                out_next.whole = integ4_reg[DW-1:0];
                out_next.frac  = frac4_reg;
                out_next.ovf   = 1'b0;
            end
        end
    end

    res_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign res_negative = out_reg.neg;
    assign res_whole    = out_reg.whole;
    assign res_fraction = out_reg.frac;
    assign out_of_range = out_reg.ovf;

endmodule

[tb/sv/decimal_fixed_add_sub_mul_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_fixed_add_sub_mul_test
// Self-checking bench: a queue-fed driver offers add, subtract and multiply
// beats, a clocked monitor compares every result beat with a predicted value.
// ----------------------------------------------------------------------------
module decimal_fixed_add_sub_mul_test;
    import dfasm_pkg::*;

    localparam logic [63:0] SCALE = 64'd1000000000000000000;
    localparam logic [63:0] HALF  = 64'd500000000000000000;
    localparam int LATENCY = 11;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]    kind;
        logic          a_neg;
        logic [DW-1:0] a_w;
        logic [DW-1:0] a_f;
        logic          b_neg;
        logic [DW-1:0] b_w;
        logic [DW-1:0] b_f;
    } operands_t;

    typedef struct {
        logic          neg;
        logic [DW-1:0] whole;
        logic [DW-1:0] frac;
        logic          ovf;
    } sum_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] kind;
    logic a_negative;
    logic [DW-1:0] a_whole;
    logic [DW-1:0] a_fraction;
    logic b_negative;
    logic [DW-1:0] b_whole;
    logic [DW-1:0] b_fraction;
    logic out_valid;
    logic out_ready;
    logic res_negative;
    logic [DW-1:0] res_whole;
    logic [DW-1:0] res_fraction;
    logic out_of_range;

    operands_t pending_ops[$];
    sum_t      expected_sums[$];
    int        mismatches;
    longint    cycles;
    bit        feed_done;
    bit        hold_sender;
    bit        hold_receiver;

    decimal_fixed_add_sub_mul dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .a_negative(a_negative), .a_whole(a_whole),
        .a_fraction(a_fraction), .b_negative(b_negative), .b_whole(b_whole),
        .b_fraction(b_fraction),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_negative(res_negative), .res_whole(res_whole),
        .res_fraction(res_fraction), .out_of_range(out_of_range)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Clamp a part to the largest legal value
    function automatic logic [63:0] clamp_part(input logic [DW-1:0] v);
        return ({4'd0, v} >= SCALE) ? SCALE - 64'd1 : {4'd0, v};
    endfunction

    // Product of two parts split into quotient and remainder by 10^18
    function automatic void split_product(input logic [63:0] x, input logic [63:0] y,
                                          output logic [63:0] q, output logic [63:0] r);
        logic [127:0] p;
        p = x * y;
        q = 64'(p / SCALE);
        r = 64'(p % SCALE);
    endfunction

    function automatic sum_t decimal_result(input operands_t op);
        logic [63:0] aw, af, bw, bf, q, r, integ, frac;
        logic [63:0] gw, gf, lw, lf;
        logic eff_b_neg, is_sub, a_less, equal;
        sum_t res;
        aw = clamp_part(op.a_w);
        af = clamp_part(op.a_f);
        bw = clamp_part(op.b_w);
        bf = clamp_part(op.b_f);
        res = '{neg: 1'b0, whole: '0, frac: '0, ovf: 1'b0};
        if (op.kind[KIND_MUL_BIT])
        begin
            split_product(af, bf, q, r);
            frac = q + ((r > HALF) ? 64'd1 : 64'd0);
            split_product(aw, bf, q, r);
            integ = q;
            frac += r;
            integ += frac / SCALE;
            frac %= SCALE;
            split_product(af, bw, q, r);
            frac += r;
            integ += frac / SCALE;
            frac %= SCALE;
            integ += q;
            split_product(aw, bw, q, r);
            integ += r;
            res.ovf = (integ >= SCALE) || (q != 0);
            res.whole = integ[DW-1:0];
            res.frac = frac[DW-1:0];
            res.neg = op.a_neg ^ op.b_neg;
        end
        else
        begin
            is_sub = (op.kind == KIND_SUB);
            eff_b_neg = op.b_neg ^ is_sub;
            if (op.a_neg == eff_b_neg)
            begin
                frac = af + bf;
                integ = aw + bw;
                if (frac >= SCALE)
                begin
                    frac -= SCALE;
                    integ += 64'd1;
                end
                res.whole = integ[DW-1:0];
                res.frac = frac[DW-1:0];
                res.neg = op.a_neg;
                res.ovf = integ >= SCALE;
            end
            else
            begin
                a_less = (aw < bw) || (aw == bw && af < bf);
                equal = (aw == bw) && (af == bf);
                gw = a_less ? bw : aw;
                gf = a_less ? bf : af;
                lw = a_less ? aw : bw;
                lf = a_less ? af : bf;
                if (gf < lf)
                begin
                    gf += SCALE;
                    gw -= 64'd1;
                end
                res.frac = DW'(gf - lf);
                res.whole = DW'(gw - lw);
                if (equal)
                    res.neg = is_sub ? op.a_neg : 1'b0;
                else
                    res.neg = a_less ? eff_b_neg : op.a_neg;
            end
        end
        if (res.ovf)
        begin
            res.neg = 1'b0;
            res.whole = '0;
            res.frac = '0;
        end
        return res;
    endfunction

    // Random part value: mostly legal, sometimes edge or out of range
    function automatic logic [DW-1:0] random_part(input int tiny);
        int pick;
        pick = $urandom_range(0, 15);
        if (tiny != 0 && pick < 8)
            return DW'($urandom_range(0, 1000));
        case (pick)
            0: return '0;
            1: return DW'(SCALE - 64'd1);
            2: return DW'({$urandom, $urandom});
            3: return DW'(HALF);
            4: return DW'($urandom_range(0, 1000000000));
            default: return DW'({$urandom, $urandom} % SCALE);
        endcase
    endfunction

    function automatic operands_t random_operands();
        operands_t op;
        int tiny;
        tiny = $urandom_range(0, 2);
        op.kind = 2'($urandom_range(0, 3));
        op.a_neg = 1'($urandom);
        op.b_neg = 1'($urandom);
        op.a_w = random_part(tiny);
        op.a_f = random_part(0);
        op.b_w = random_part(tiny);
        op.b_f = random_part(0);
        // Aim some beats at near-equal magnitudes
        if ($urandom_range(0, 9) == 0)
        begin
            op.b_w = op.a_w;
            op.b_f = ($urandom_range(0, 1) != 0) ? op.a_f : op.a_f + DW'(1);
        end
        return op;
    endfunction

    task automatic push_op(input logic [1:0] k, input logic an, input logic [63:0] aw,
                           input logic [63:0] af, input logic bn, input logic [63:0] bw,
                           input logic [63:0] bf);
        operands_t op;
        op = '{kind: k, a_neg: an, a_w: aw[DW-1:0], a_f: af[DW-1:0],
               b_neg: bn, b_w: bw[DW-1:0], b_f: bf[DW-1:0]};
        pending_ops.push_back(op);
    endtask

    // Driver: advance through the queue, hold the beat until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_ADD;
            a_negative <= 1'b0;
            a_whole <= '0;
            a_fraction <= '0;
            b_negative <= 1'b0;
            b_whole <= '0;
            b_fraction <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_sums.push_back(decimal_result('{kind, a_negative, a_whole,
                    a_fraction, b_negative, b_whole, b_fraction}));
            if (!hold_sender && pending_ops.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                operands_t op;
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                kind <= op.kind;
                a_negative <= op.a_neg;
                a_whole <= op.a_w;
                a_fraction <= op.a_f;
                b_negative <= op.b_neg;
                b_whole <= op.b_w;
                b_fraction <= op.b_f;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: short random gaps, occasional long ones
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_receiver)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat: neg %0d whole %0d frac %0d ovf %0d",
                             res_negative, res_whole, res_fraction, out_of_range);
            end
            else
            begin
                sum_t want;
                want = expected_sums.pop_front();
                if (want.neg !== res_negative || want.whole !== res_whole ||
                    want.frac !== res_fraction || want.ovf !== out_of_range)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch: want %0d %0d.%0d ovf %0d, got %0d %0d.%0d ovf %0d",
                                 want.neg, want.whole, want.frac, want.ovf,
                                 res_negative, res_whole, res_fraction, out_of_range);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] top;
        top = SCALE - 64'd1;
        rst_n = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_sender = 1'b1;
        hold_receiver = 1'b0;
        // Directed: extremes, every kind, equal magnitudes, overflow, rounding
        push_op(KIND_ADD, 0, 0, 0, 0, 0, 0);
        push_op(KIND_ADD, 0, top, top, 0, top, top);
        push_op(KIND_ADD, 0, top - 1, top, 0, 0, 1);
        push_op(KIND_ADD, 0, 5, 7, 1, 5, 7);
        push_op(KIND_SUB, 1, 5, 7, 1, 5, 7);
        push_op(KIND_SUB, 0, 5, 7, 0, 5, 7);
        push_op(KIND_SUB, 0, 3, 1, 0, 4, 2);
        push_op(KIND_SUB, 1, 3, 9, 0, 4, 2);
        push_op(KIND_ADD, 1, 3, 9, 0, 3, 2);
        push_op(KIND_SUB, 0, top, top, 1, top, top);
        push_op(KIND_MUL, 0, 0, 0, 1, top, top);
        push_op(KIND_MUL, 1, top, top, 1, top, top);
        push_op(KIND_MUL, 0, 1, 0, 0, top, top);
        push_op(KIND_MUL, 0, 0, HALF, 0, 0, 1);
        push_op(KIND_MUL, 0, 0, HALF, 0, 0, 3);
        push_op(KIND_MUL, 1, 1000000000, 0, 0, 1000000000, 0);
        push_op(KIND_MUL, 0, 999999999, 0, 0, 1000000001, 0);
        push_op(KIND_SPARE, 1, 2, HALF, 0, 3, 0);
        push_op(KIND_ADD, 0, {64{1'b1}}, {64{1'b1}}, 1, 0, 0);
        push_op(KIND_SUB, 1, 0, 0, 0, {64{1'b1}}, {64{1'b1}});
        push_op(KIND_SPARE, 0, {64{1'b1}}, 0, 0, 0, 0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        hold_sender <= 1'b0;
        wait (pending_ops.size() == 0);
        // Long receiver hold while the sender keeps offering beats
        repeat (80) pending_ops.push_back(random_operands());
        @(posedge clk);
        hold_receiver <= 1'b1;
        repeat (200) @(posedge clk);
        hold_receiver <= 1'b0;
        wait (pending_ops.size() == 0);
        // Sender pause until everything has drained
        hold_sender <= 1'b1;
        @(posedge clk);
        while (expected_sums.size() != 0 || in_valid)
            @(posedge clk);
        hold_sender <= 1'b0;
        repeat (950) pending_ops.push_back(random_operands());
        wait (pending_ops.size() == 0);
        @(posedge clk);
        while (expected_sums.size() != 0 || in_valid)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
